// File: sv/oahi_pkg.sv
`default_nettype none

package oahi_pkg;

  localparam int DEF_MAX_SLOTS = 32;
  localparam int KEY_SPACE = 256;
  localparam int KEY_W = 8;
  localparam int SLOT_W = 5;
  localparam int COLL_W = 6;
  localparam int TOTAL_W = 16;
  localparam int CFG_W = 6;
  localparam int CMD_W = 2;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 6'd23;
  localparam int COLL_MAX = 63;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_TABLE_SIZE = 1'b0,
    REG_PROBE_MODE = 1'b1
  } reg_index_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_DECODE = 8'b00000010,
    ST_DIV    = 8'b00000100,
    ST_SEEK   = 8'b00001000,
    ST_PROBE  = 8'b00010000,
    ST_READ   = 8'b00100000,
    ST_CLEAR  = 8'b01000000,
    ST_RESULT = 8'b10000000
  } state_t;

endpackage

`default_nettype wire

// File: sv/oahi_ram.sv
`default_nettype none

module oahi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/open_address_hash_insert_unit.sv
`default_nettype none

// Channel   Direction  Contents
// s_*       in         tdata: key[7:0], slot_index[12:8]; tuser: cmd[1:0]
// m_*       out        tdata: slot, stored_key, probe_collisions, total_collisions;
//                      tuser: placed, duplicate, table_full
// cfg_*     in         write enable, register index, data
//
// An insert steps through accept, decode, one remainder step per key bit, a table fetch,
// probes of one slot after another (up to the table size in use) and a result step.
// A read adds a read step; duplicate and ignored commands go from decode to the result.
// Reset and each clear run a pass over all 256 seen map entries, with s_tready low.
// A result waits in the output register while m_tready is low; the next transaction may be
// taken meanwhile, and its result is held back until the register is free.

module open_address_hash_insert_unit
  import oahi_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,  // key[7:0], slot_index[12:8]
  input  wire logic [1:0]   s_tuser,  // cmd[1:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [39:0]  m_tdata,  // slot[4:0], stored_key[12:5],
                                      // probe_collisions[18:13], total_collisions[34:19]
  output logic      [2:0]   m_tuser,  // placed[0], duplicate[1], table_full[2]
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [5:0]   cfg_data
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int MW = $clog2(MAX_SLOTS + 1);
  localparam int SW = MW + 1;

  function automatic logic [MW-1:0] mod_add(input logic [MW-1:0] a, input logic [MW-1:0] b,
                                            input logic [MW-1:0] mm);
    logic [SW-1:0] sum;
    sum = SW'(a) + SW'(b);
    if (sum >= SW'(mm)) begin
      sum = sum - SW'(mm);
    end
    return MW'(sum);
  endfunction

  state_t state;
  logic [CFG_W-1:0] table_size;
  logic probe_mode;
  logic [MAX_SLOTS-1:0] slot_valid;
  logic [TOTAL_W-1:0] total;

  cmd_t cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [SLOT_W-1:0] sidx_q;
  logic [KEY_W-1:0] key_sh;
  logic [2:0] div_cnt;
  logic [MW-1:0] m_q, m_cur, rem, pos, q, d, steps, coll;
  logic [SW-1:0] div_t;
  logic [MW-1:0] div_r, pos_next, d_init;
  logic [IW-1:0] ram_raddr, rd_addr_q;
  logic [KEY_W-1:0] ram_rdata, entry;
  logic ram_we;

  logic [KEY_W-1:0] clr_addr;
  logic clr_reply;
  logic seen_we;
  logic [KEY_W-1:0] seen_waddr, seen_raddr;
  logic seen_wdata;
  logic seen_rdata;

  logic [SLOT_W-1:0] res_slot;
  logic [KEY_W-1:0] res_key;
  logic [2:0] res_flags;
  logic [MW-1:0] res_coll;
  logic [MW-1:0] coll_next;
  logic [TOTAL_W:0] total_sum;
  logic [TOTAL_W-1:0] total_sat;
  logic [COLL_W-1:0] coll_out;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    if (table_size < CFG_W'(2)) begin
      m_cur = MW'(2);
    end else if (int'(table_size) > MAX_SLOTS) begin
      m_cur = MW'(MAX_SLOTS);
    end else begin
      m_cur = MW'(table_size);
    end
  end

  always_comb begin
    div_t = {rem, key_sh[KEY_W-1]};
    if (div_t >= SW'(m_q)) begin
      div_t = div_t - SW'(m_q);
    end
    div_r = MW'(div_t);
  end

  always_comb begin
    if (m_q == MW'(2)) begin
      d_init = MW'(1);
    end else if (m_q == MW'(3)) begin
      d_init = '0;
    end else begin
      d_init = MW'(3);
    end
  end

  assign pos_next = mod_add(pos, probe_mode ? q : MW'(1), m_q);
  assign entry = slot_valid[rd_addr_q] ? ram_rdata : '0;
  assign coll_next = (entry != '0 && entry != key_q) ? coll + MW'(1) : coll;
  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'(coll_next);
  assign total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
  assign coll_out = (int'(res_coll) > COLL_MAX) ? COLL_W'(COLL_MAX) : COLL_W'(res_coll);
  assign ram_we = (state == ST_PROBE) && (entry == '0);

  assign seen_raddr = s_tready ? s_tdata[KEY_W-1:0] : key_q;
  assign seen_we = (state == ST_CLEAR) ||
                   (state == ST_DECODE && cmd_q == CMD_INSERT && key_q != '0 && !seen_rdata);
  assign seen_waddr = (state == ST_CLEAR) ? clr_addr : key_q;
  assign seen_wdata = (state != ST_CLEAR);

  always_comb begin
    priority if (state == ST_DECODE) begin
      ram_raddr = IW'(sidx_q);
    end else if (state == ST_PROBE) begin
      ram_raddr = IW'(pos_next);
    end else begin
      ram_raddr = IW'(pos);
    end
  end

  oahi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(pos)),
    .wdata (key_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  oahi_ram #(
    .WIDTH (1),
    .DEPTH (KEY_SPACE)
  ) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (seen_raddr),
    .rdata (seen_rdata)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_raddr;
    if (s_tvalid && s_tready) begin
      cmd_q <= cmd_t'(s_tuser);
      key_q <= s_tdata[7:0];
      sidx_q <= s_tdata[12:8];
    end
    unique case (state)
      ST_DECODE: begin
        res_slot <= '0;
        res_key <= '0;
        res_flags <= '0;
        res_coll <= '0;
        m_q <= m_cur;
        key_sh <= key_q;
        rem <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem <= div_r;
        key_sh <= {key_sh[KEY_W-2:0], 1'b0};
        div_cnt <= div_cnt + 3'd1;
        if (div_cnt == 3'd7) begin
          pos <= div_r;
          q <= MW'(1);
          d <= d_init;
          steps <= '0;
          coll <= '0;
        end
      end
      ST_PROBE: begin
        if (entry == '0) begin
          res_slot <= SLOT_W'(pos);
          res_key <= key_q;
          res_flags <= 3'b001;
          res_coll <= coll;
        end else begin
          coll <= coll_next;
          pos <= pos_next;
          q <= mod_add(q, d, m_q);
          d <= mod_add(d, MW'(2), m_q);
          steps <= steps + MW'(1);
          res_coll <= coll_next;
          res_flags <= 3'b100;
        end
      end
      ST_READ: begin
        res_slot <= sidx_q;
        res_key <= (int'(sidx_q) < MAX_SLOTS) ? entry : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      table_size <= TABLE_SIZE_RESET;
      probe_mode <= 1'b0;
      slot_valid <= '0;
      total <= '0;
      clr_addr <= '0;
      clr_reply <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata <= '0;
      m_tuser <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_TABLE_SIZE: table_size <= cfg_data;
          REG_PROBE_MODE: probe_mode <= cfg_data[0];
        endcase
      end
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (cmd_q)
            CMD_INSERT: begin
              if (key_q == '0) begin
                state <= ST_RESULT;
              end else if (seen_rdata) begin
                state <= ST_RESULT;
              end else begin
                state <= ST_DIV;
              end
            end
            CMD_CLEAR: begin
              slot_valid <= '0;
              total <= '0;
              clr_addr <= '0;
              clr_reply <= 1'b1;
              state <= ST_CLEAR;
            end
            CMD_READ: state <= ST_READ;
            CMD_NONE: state <= ST_RESULT;
          endcase
        end
        ST_DIV: begin
          if (div_cnt == 3'd7) begin
            state <= ST_SEEK;
          end
        end
        ST_SEEK: state <= ST_PROBE;
        ST_PROBE: begin
          if (entry == '0) begin
            slot_valid[IW'(pos)] <= 1'b1;
            total <= total_sat;
            state <= ST_RESULT;
          end else if (steps + MW'(1) == m_q) begin
            total <= total_sat;
            state <= ST_RESULT;
          end
        end
        ST_READ: state <= ST_RESULT;
        ST_CLEAR: begin
          clr_addr <= clr_addr + KEY_W'(1);
          if (clr_addr == '1) begin
            clr_reply <= 1'b0;
            state <= clr_reply ? ST_RESULT : ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {5'd0, total, coll_out, res_key, res_slot};
            m_tuser <= (cmd_q == CMD_INSERT && key_q != '0 && res_flags == '0) ?
                       3'b010 : res_flags;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> (pos < m_q) && (steps < m_q))
    else $error("probe position or count out of range");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("more than one result flag set");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[12:5] != '0)
    else $error("placed result without a key");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("waiting result changed");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> total == '0)
    else $error("total not zero during the clearing pass");

endmodule

`default_nettype wire
